FILE: src/imt_pkg.sv
// Shared types and constants of the interval merge table.
`default_nettype none

package imt_pkg;

   localparam int COUNT_W = 16;
   localparam int SLACK_W = 8;
   localparam int START_W = 7;
   localparam int MSLOT_W = 6;

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [SLACK_W-1:0] slack_type;

   localparam count_type COUNT_MAX   = {COUNT_W{1'b1}};
   localparam slack_type SLACK_RESET = 8'd2;

endpackage

`default_nettype wire

FILE: src/imt_table.sv
// Entry store of the interval table: one write port and one registered read port.
`default_nettype none

module imt_table #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 48
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: src/imt_match.sv
// Compare and merge unit applied to one stored entry per cycle.
`default_nettype none

module imt_match #(
   parameter int POS_WIDTH = 16
) (
   input  wire logic [POS_WIDTH-1:0] cur_begin,
   input  wire logic [POS_WIDTH-1:0] cur_end,
   input  wire imt_pkg::count_type   cur_count,
   input  wire logic [POS_WIDTH-1:0] ent_begin,
   input  wire logic [POS_WIDTH-1:0] ent_end,
   input  wire imt_pkg::count_type   ent_count,
   input  wire imt_pkg::slack_type   slack,
   output logic                      hit,
   output logic [POS_WIDTH-1:0]      new_begin,
   output logic [POS_WIDTH-1:0]      new_end,
   output imt_pkg::count_type        new_count
);

   logic [POS_WIDTH:0]        end_slack;
   logic [POS_WIDTH:0]        ent_end_slack;
   logic [imt_pkg::COUNT_W:0] sum;

   // Slack sums carry one extra bit so they never wrap.
   assign end_slack     = {1'b0, cur_end} + (POS_WIDTH+1)'(slack);
   assign ent_end_slack = {1'b0, ent_end} + (POS_WIDTH+1)'(slack);
   assign sum           = {1'b0, cur_count} + {1'b0, ent_count};

   always_comb begin
      hit       = 1'b0;
      new_begin = cur_begin;
      new_end   = cur_end;
      priority if (cur_begin <= ent_begin && end_slack >= {1'b0, ent_begin}
                   && cur_end <= ent_end) begin
         hit     = 1'b1;
         new_end = ent_end;
      end else if (cur_begin <= ent_begin && cur_end >= ent_end) begin
         hit = 1'b1;
      end else if (cur_begin >= ent_begin && cur_end <= ent_end) begin
         hit       = 1'b1;
         new_begin = ent_begin;
         new_end   = ent_end;
      end else if (cur_begin >= ent_begin && {1'b0, cur_begin} <= ent_end_slack) begin
         hit       = 1'b1;
         new_begin = ent_begin;
      end else begin
         hit = 1'b0;
      end
   end

   assign new_count = sum[imt_pkg::COUNT_W] ? imt_pkg::COUNT_MAX
                                            : sum[imt_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire

FILE: src/interval_merge_table_unit.sv
// Top level of the interval merge table: sequencer, fill count and stream ports.
//
// Usage. An item arrives on the req_ stream: an interval, its hit count and the
// slot where the search starts. The block walks the stored entries from that
// slot upward, one entry per cycle through a single compare unit, and stops at
// the first entry that the interval can merge with. A matching entry is removed
// and the entries above it move down one slot, again one per cycle through the
// single table write port. Without a match the interval is appended, or dropped
// with the overflow flag raised when the table is full. Exactly one result
// transfer follows on the rsp_ stream for every accepted item.
// Each item runs from the idle state through the scan state, which a start slot
// at or above the fill count skips, then the shift or the append state, and the
// finish state. The number of entries compared plus the number moved never
// exceeds the fill count. req_tready is low while an item is in work, so a new
// item is taken only after the previous one has left the finish state.
// The result sits in an output register, so a new item is taken while an older
// result still waits; a finished item then waits until that result is taken.
// Reset empties the table at once (fill count to zero, no clearing pass) and
// sets merge_slack to 2. A csr_ write transfer, taken in any cycle, sets it.
`default_nettype none

module interval_merge_table_unit #(
   parameter int TABLE_DEPTH = 64,
   parameter int POS_WIDTH   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration: merge_slack.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data,
   // Input item.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // range_begin[15:0], range_end[31:16], hit_count[47:32], start_slot[54:48], zero[55]
   input  wire logic [55:0] req_tdata,
   // Result item.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // merged_slot[5:0], out_begin[21:6], out_end[37:22], out_count[53:38], zero[55:54]
   output logic [55:0]      rsp_tdata,
   // merged[0], overflow[1]
   output logic [1:0]       rsp_tuser
);

   localparam int SLOT_W  = $clog2(TABLE_DEPTH);
   localparam int FILL_W  = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W   = (FILL_W > imt_pkg::START_W) ? FILL_W : imt_pkg::START_W;
   localparam int ENTRY_W = 2 * POS_WIDTH + imt_pkg::COUNT_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_SHIFT  = 3'd2;
   localparam logic [2:0] ST_APPEND = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [FILL_W-1:0]        ptr_ff, ptr_in;
   logic [FILL_W:0]          rd_ptr_ff, rd_ptr_in;
   imt_pkg::slack_type       slack_ff, slack_in;
   logic [POS_WIDTH-1:0]     cur_begin_ff, cur_begin_in;
   logic [POS_WIDTH-1:0]     cur_end_ff, cur_end_in;
   imt_pkg::count_type       cur_count_ff, cur_count_in;
   logic                     hit_ff, hit_in;
   logic                     ovf_ff, ovf_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [55:0]              rsp_data_ff, rsp_data_in;
   logic [1:0]               rsp_user_ff, rsp_user_in;

   logic                     req_fire;
   logic [imt_pkg::START_W-1:0] req_start;
   logic                     start_beyond;
   logic                     ptr_last;

   logic                     wr_en;
   logic [SLOT_W-1:0]        wr_addr;
   logic [ENTRY_W-1:0]       wr_data;
   logic [SLOT_W-1:0]        rd_addr;
   logic [ENTRY_W-1:0]       rd_data;

   logic [POS_WIDTH-1:0]     ent_begin;
   logic [POS_WIDTH-1:0]     ent_end;
   imt_pkg::count_type       ent_count;
   logic                     m_hit;
   logic [POS_WIDTH-1:0]     m_begin;
   logic [POS_WIDTH-1:0]     m_end;
   imt_pkg::count_type       m_count;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_start  = req_tdata[54:48];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A start slot at or above the fill count skips the search entirely.
   assign start_beyond = CMP_W'(req_start) >= CMP_W'(fill_ff);
   // True when the pointer names the top valid entry.
   assign ptr_last = ({1'b0, ptr_ff} + (FILL_W+1)'(1)) >= {1'b0, fill_ff};

   assign ent_begin = rd_data[POS_WIDTH-1:0];
   assign ent_end   = rd_data[2*POS_WIDTH-1:POS_WIDTH];
   assign ent_count = rd_data[ENTRY_W-1:2*POS_WIDTH];

   imt_table #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   imt_match #(
      .POS_WIDTH (POS_WIDTH)
   ) u_match (
      .cur_begin (cur_begin_ff),
      .cur_end   (cur_end_ff),
      .cur_count (cur_count_ff),
      .ent_begin (ent_begin),
      .ent_end   (ent_end),
      .ent_count (ent_count),
      .slack     (slack_ff),
      .hit       (m_hit),
      .new_begin (m_begin),
      .new_end   (m_end),
      .new_count (m_count)
   );

   // The registered read data is the entry at ptr_ff in the scan state and
   // the entry above it in the shift state.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      slack_in     = slack_ff;
      cur_begin_in = cur_begin_ff;
      cur_end_in   = cur_end_ff;
      cur_count_in = cur_count_ff;
      hit_in       = hit_ff;
      ovf_in       = ovf_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      wr_addr      = fill_ff[SLOT_W-1:0];
      wr_data      = {cur_count_ff, cur_end_ff, cur_begin_ff};
      rd_addr      = rd_ptr_ff[SLOT_W-1:0];

      if (csr_valid && csr_ready) begin
         slack_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = SLOT_W'(req_start);
            if (req_fire) begin
               cur_begin_in = POS_WIDTH'(req_tdata[15:0]);
               cur_end_in   = POS_WIDTH'(req_tdata[31:16]);
               cur_count_in = req_tdata[47:32];
               hit_in       = 1'b0;
               ovf_in       = 1'b0;
               slot_in      = '0;
               ptr_in       = FILL_W'(req_start);
               rd_ptr_in    = (FILL_W+1)'(req_start) + (FILL_W+1)'(1);
               state_in     = start_beyond ? ST_APPEND : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_ptr_in = rd_ptr_ff + (FILL_W+1)'(1);
            if (m_hit) begin
               cur_begin_in = m_begin;
               cur_end_in   = m_end;
               cur_count_in = m_count;
               hit_in       = 1'b1;
               slot_in      = ptr_ff[SLOT_W-1:0];
               state_in     = ST_SHIFT;
            end else if (ptr_last) begin
               state_in = ST_APPEND;
            end else begin
               ptr_in = ptr_ff + FILL_W'(1);
            end
         end
         ST_SHIFT: begin
            // ptr_ff is the slot being filled; the read data is the slot above.
            if (ptr_last) begin
               fill_in  = fill_ff - FILL_W'(1);
               state_in = ST_FINISH;
            end else begin
               wr_en     = 1'b1;
               wr_addr   = ptr_ff[SLOT_W-1:0];
               wr_data   = rd_data;
               ptr_in    = ptr_ff + FILL_W'(1);
               rd_ptr_in = rd_ptr_ff + (FILL_W+1)'(1);
            end
         end
         ST_APPEND: begin
            if (fill_ff < FILL_W'(TABLE_DEPTH)) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + FILL_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, cur_count_ff, 16'(cur_end_ff), 16'(cur_begin_ff),
                               imt_pkg::MSLOT_W'(slot_ff)};
               rsp_user_in  = {ovf_ff, hit_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         slack_ff     <= imt_pkg::SLACK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         slack_ff     <= slack_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      rd_ptr_ff    <= rd_ptr_in;
      cur_begin_ff <= cur_begin_in;
      cur_end_ff   <= cur_end_in;
      cur_count_ff <= cur_count_in;
      hit_ff       <= hit_in;
      ovf_ff       <= ovf_in;
      slot_ff      <= slot_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   // The fill count never passes the table depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TABLE_DEPTH))
      else $error("fill count above table depth");

   // A result never reports both a merge and a dropped append.
   a_merge_xor_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_user_ff[0] && rsp_user_ff[1]))
      else $error("merged and overflow both set");

   // An accepted item always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("item accepted but sequencer idle");

   // Entry moves stay inside the valid part of the table.
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> ptr_ff < fill_ff)
      else $error("compaction pointer beyond fill count");

   // The table shrinks by one only when a merge completes.
   a_fill_drop: assert property (@(posedge clock) disable iff (reset)
      (fill_ff < $past(fill_ff)) |-> $past(state_ff == ST_SHIFT) && hit_ff)
      else $error("fill count dropped without a merge");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench of the interval merge table: directed merges, a full table, random traffic.
module testbench;

   localparam int DEPTH = 64;
   localparam int POS_MAX = 65535;
   localparam int WALK_CYCLES = 2 * DEPTH + 10;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 210;

   // One offered interval, laid out exactly as req_tdata carries it (lowest field last).
   typedef struct packed {
      logic [imt_pkg::START_W-1:0] first_slot;
      imt_pkg::count_type          count;
      logic [15:0]                 hi;
      logic [15:0]                 lo;
   } span_item_type;

   // One result: rsp_tuser bits on top of the 54 used bits of rsp_tdata.
   typedef struct packed {
      logic                        overflow;
      logic                        merged;
      imt_pkg::count_type          count;
      logic [15:0]                 hi;
      logic [15:0]                 lo;
      logic [imt_pkg::MSLOT_W-1:0] slot;
   } merge_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic [7:0]  csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic [55:0] req_tdata = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_ready;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // Our own copy of the interval table and the slack register.
   logic [15:0]        stored_begin [DEPTH];
   logic [15:0]        stored_end [DEPTH];
   imt_pkg::count_type stored_count [DEPTH];
   int                 stored_fill = 0;
   imt_pkg::slack_type slack_setting = imt_pkg::SLACK_RESET;

   merge_outcome_type pending_outcomes [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                rsp_hold = 0;
   bit                steady_flow = 1'b0;

   interval_merge_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Scans from the start slot for the first mergeable entry, then removes it
   // and closes the gap; with no match it appends the interval, or flags overflow when full.
   function automatic merge_outcome_type merge_into_table(input span_item_type item);
      merge_outcome_type res;
      int lo, hi, sum, b2, e2, slack, idx, k;
      bit hit;
      res = '0;
      lo = item.lo;
      hi = item.hi;
      sum = item.count;
      slack = slack_setting;
      hit = 1'b0;
      idx = item.first_slot;
      while (!hit && idx < stored_fill) begin
         b2 = stored_begin[idx];
         e2 = stored_end[idx];
         if (lo <= b2 && hi + slack >= b2 && hi <= e2) begin
            hi = e2;
            hit = 1'b1;
         end else if (lo <= b2 && hi >= e2) begin
            hit = 1'b1;
         end else if (lo >= b2 && hi <= e2) begin
            lo = b2;
            hi = e2;
            hit = 1'b1;
         end else if (lo >= b2 && lo <= e2 + slack) begin
            lo = b2;
            hit = 1'b1;
         end
         if (!hit) idx++;
      end
      if (hit) begin
         sum += stored_count[idx];
         if (sum > int'(imt_pkg::COUNT_MAX)) sum = int'(imt_pkg::COUNT_MAX);
         for (k = idx; k + 1 < stored_fill; k++) begin
            stored_begin[k] = stored_begin[k + 1];
            stored_end[k] = stored_end[k + 1];
            stored_count[k] = stored_count[k + 1];
         end
         stored_fill--;
         res.slot = imt_pkg::MSLOT_W'(idx);
      end else if (stored_fill < DEPTH) begin
         stored_begin[stored_fill] = 16'(lo);
         stored_end[stored_fill] = 16'(hi);
         stored_count[stored_fill] = imt_pkg::count_type'(sum);
         stored_fill++;
      end else begin
         res.overflow = 1'b1;
      end
      res.merged = hit;
      res.lo = 16'(lo);
      res.hi = 16'(hi);
      res.count = imt_pkg::count_type'(sum);
      return res;
   endfunction

   function automatic span_item_type make_span(input int lo, input int hi, input int count,
                                               input int slot);
      span_item_type s;
      s.lo = 16'(lo);
      s.hi = 16'(hi);
      s.count = imt_pkg::count_type'(count);
      s.first_slot = imt_pkg::START_W'(slot);
      return s;
   endfunction

   function automatic int clamp_pos(input int p);
      if (p < 0) return 0;
      if (p > POS_MAX) return POS_MAX;
      return p;
   endfunction

   // A related_pct share of items is built around a stored entry so that all four merge tests fire,
   // close to the slack boundary on both sides; the rest are fresh, far-start or noise.
   function automatic span_item_type random_span(input int related_pct, input int fresh_pct);
      int mode, lo, hi, b2, e2, reach, cnt, slot, pick;
      mode = $urandom_range(0, 99);
      cnt = ($urandom_range(0, 7) == 0) ? int'($urandom_range(65000, 65535))
                                        : int'($urandom_range(0, 65535));
      slot = 0;
      if (mode < related_pct && stored_fill > 0) begin
         pick = $urandom_range(0, stored_fill - 1);
         b2 = stored_begin[pick];
         e2 = stored_end[pick];
         reach = int'(slack_setting) + 4;
         lo = b2 + int'($urandom_range(0, 120)) - 60;
         hi = e2 + int'($urandom_range(0, 120)) - 60;
         case ($urandom_range(0, 3))
            0: begin
               hi = b2 - int'($urandom_range(0, reach));
               lo = hi - int'($urandom_range(0, 80));
            end
            1: begin
               lo = e2 + int'($urandom_range(0, reach));
               hi = lo + int'($urandom_range(0, 80));
            end
            default: ;
         endcase
         if ($urandom_range(0, 3) == 0) slot = $urandom_range(0, pick);
      end else if (mode < related_pct + fresh_pct) begin
         lo = $urandom_range(0, POS_MAX);
         hi = lo + int'($urandom_range(0, 300));
         slot = $urandom_range(0, DEPTH);
      end else if (mode < related_pct + fresh_pct + 10) begin
         // Start at or past the fill level, so nothing is scanned.
         lo = $urandom_range(0, POS_MAX);
         hi = lo + int'($urandom_range(0, 300));
         slot = $urandom_range(stored_fill, DEPTH);
      end else begin
         lo = $urandom_range(0, POS_MAX);
         hi = $urandom_range(0, POS_MAX);
         slot = $urandom_range(0, DEPTH);
      end
      return make_span(clamp_pos(lo), clamp_pos(hi), cnt, slot);
   endfunction

   // Offers one interval and records its outcome once req_tready is seen high again.
   task automatic send_span(input span_item_type item);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, item};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_outcomes = {pending_outcomes, merge_into_table(item)};
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_slack(input imt_pkg::slack_type value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      slack_setting = value;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Result side: random back-pressure after each transfer unless in steady flow, and the field checks.
   always @(posedge clock) begin : rsp_side
      merge_outcome_type seen, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tuser[1], rsp_tuser[0], rsp_tdata[53:0]};
            if (pending_outcomes.size() == 0) begin
               $error("result transfer with no outstanding item");
               mismatch_count++;
            end else begin
               want = pending_outcomes.pop_front();
               compare_field("merged", want.merged, seen.merged);
               compare_field("merged_slot", want.slot, seen.slot);
               compare_field("out_begin", want.lo, seen.lo);
               compare_field("out_end", want.hi, seen.hi);
               compare_field("out_count", want.count, seen.count);
               compare_field("overflow", want.overflow, seen.overflow);
            end
            rsp_hold = steady_flow ? 0 : $urandom_range(0, 10);
         end
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Reset slack of 2: each merge test, slack edges, saturation, reversed intervals.
   task automatic test_merge_cases();
      send_span(make_span(100, 200, 5, 0));
      send_span(make_span(1000, 1100, 7, 0));
      send_span(make_span(3000, 3050, 65535, 0));
      send_span(make_span(4000, 4000, 9, 0));
      send_span(make_span(95, 98, 4, 0));         // ends within the slack before an entry
      send_span(make_span(900, 1200, 3, 0));      // contains an entry
      send_span(make_span(3010, 3020, 10, 0));    // contained, count saturates
      send_span(make_span(4002, 4100, 1, 0));     // starts within the slack after an entry
      send_span(make_span(0, 10, 1, 0));
      send_span(make_span(65530, 65535, 2, 0));
      send_span(make_span(500, 600, 3, 0));
      send_span(make_span(65535, 65535, 65535, 0));
      send_span(make_span(200, 100, 5, 0));       // reversed interval
      send_span(make_span(550, 560, 1, 1));
      send_span(make_span(0, 0, 0, 5));           // start past the fill level
      send_span(make_span(0, 0, 0, 64));
      send_span(make_span(12, 20, 0, 0));
      send_span(make_span(700, 800, 1, 0));
      send_span(make_span(803, 900, 1, 0));       // one position beyond the slack
      send_span(make_span(65535, 0, 65535, 0));
      send_span(make_span(0, 65535, 65535, 0));
   endtask

   task automatic test_slack_extremes();
      write_slack(8'd0);
      send_span(make_span(1000, 1010, 1, 64));
      send_span(make_span(1011, 1020, 1, 0));
      send_span(make_span(1010, 1015, 1, 0));
      write_slack(8'd255);
      send_span(make_span(2000, 2010, 1, 64));
      send_span(make_span(2265, 2270, 1, 0));
      send_span(make_span(1700, 1744, 1, 0));
      send_span(make_span(1745, 1745, 1, 0));
   endtask

   // Appends past the depth drop items with overflow; merges still work while full.
   task automatic test_table_full();
      int n, lo, pick;
      write_slack(8'd0);
      for (n = 0; n < DEPTH + 6; n++) begin
         lo = $urandom_range(0, POS_MAX - 50);
         send_span(make_span(lo, lo + int'($urandom_range(0, 50)),
                             $urandom_range(0, 65535), DEPTH));
      end
      for (n = 0; n < 3; n++) begin
         pick = $urandom_range(0, stored_fill - 1);
         send_span(make_span(stored_begin[pick], stored_end[pick], 1, 0));
      end
      send_span(make_span(60000, 60000, 1, DEPTH));
      send_span(make_span(60010, 60010, 1, DEPTH));
   endtask

   task automatic test_random_traffic();
      int phase, n, related, fresh;
      imt_pkg::slack_type next_slack;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: next_slack = 8'd2;
            1: next_slack = 8'd0;
            2: next_slack = 8'd255;
            3: next_slack = 8'd17;
            default: next_slack = imt_pkg::slack_type'($urandom_range(0, 255));
         endcase
         write_slack(next_slack);
         // Phase 1 favors fresh intervals to keep the table near full.
         related = (phase == 1) ? 25 : 45;
         fresh = (phase == 1) ? 55 : 30;
         steady_flow = (phase == 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) drain_results();
            send_span(random_span(related, fresh));
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_merge_cases();
      test_slack_extremes();
      test_table_full();
      test_random_traffic();
      drain_results();
      repeat (WALK_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/imt_pkg.sv
src/imt_table.sv
src/imt_match.sv
src/interval_merge_table_unit.sv
sim/testbench.sv
